// ----- rtl/core/half_duplex_serial_fifo_control_core_assert.svh -----
// Assertion helpers for the serial FIFO control core.
// Both macros expect a clock named aclk and an active-low reset named aresetn.
`ifndef HALF_DUPLEX_SERIAL_FIFO_CONTROL_CORE_ASSERT_SVH
`define HALF_DUPLEX_SERIAL_FIFO_CONTROL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDSFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hdsfc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HDSFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hdsfc assertion failed");

`endif

// ----- rtl/core/hdsfc_pkg.sv -----
`timescale 1ns / 1ps

package hdsfc_pkg;

    // Ring sizes. Each ring holds one byte less than its depth.
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ECHO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CRLF_EXPAND = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        OP_LINE_RX    = 3'd0,
        OP_HOST_READ  = 3'd1,
        OP_HOST_WRITE = 3'd2,
        OP_TX_READY   = 3'd3,
        OP_TX_DONE    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RX_EMPTY    = 3'd1,
        ST_TX_FULL     = 3'd2,
        ST_RX_OVERFLOW = 3'd3,
        ST_TX_IDLE     = 3'd4,
        ST_RX_DISABLED = 3'd5
    } status_t;

    // Source of the result byte.
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_RX   = 2'd1,
        SEL_TX   = 2'd2
    } byte_sel_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       driver_enable;
        logic       receiver_enable;
        logic       rx_available;
    } result_t;

    function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
        return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_ptr_inc(input logic [TX_PTR_W-1:0] p);
        return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + TX_PTR_W'(1);
    endfunction

endpackage

// ----- rtl/core/half_duplex_serial_fifo_control_core.sv -----
`timescale 1ns / 1ps

// Receive and transmit byte rings with half-duplex line direction control. One request
// is accepted per cycle and its result is presented from the output register in the
// next cycle. A new request is taken only while the output register is empty or its
// result leaves in the same cycle, so a stalled result side stalls the input. The one
// exception is a host write of a carriage return with expansion on: the
// line feed and the carriage return are written to the transmit store through its single
// write port one after the other, so that request holds the input until both are written.
// Both stores are block memories with registered reads; the popped byte comes
// straight from the read register. No clearing pass is needed after reset.
module half_duplex_serial_fifo_control_core
    import hdsfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_data,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    `include "half_duplex_serial_fifo_control_core_assert.svh"

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [RX_PTR_W-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_PTR_W-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic                driver_on_reg, driver_on_next;
    logic                receiver_on_reg, receiver_on_next;
    logic                local_echo_reg, crlf_expand_reg;
    logic                pend_reg, pend_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    byte_sel_t           sel_reg, sel_next;
    logic                rx_avail_reg;
    logic [7:0]          rx_rdata_reg, tx_rdata_reg;
    logic [7:0]          out_byte_mux;

    logic                accept;
    logic                rx_we, rx_re, tx_we, tx_re;
    logic [7:0]          tx_wdata;
    logic                expand;
    logic                rx_empty, rx_full, tx_empty, tx_full1, tx_full2;

    // A request is taken when the output slot frees and no expansion write is pending.
    assign s_ready   = (!out_valid_reg || m_ready) && !pend_reg;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Ring occupancy from the pointers.
    assign rx_empty = (rx_wp_reg == rx_rp_reg);
    assign rx_full  = (rx_ptr_inc(rx_wp_reg) == rx_rp_reg);
    assign tx_empty = (tx_wp_reg == tx_rp_reg);
    assign tx_full1 = (tx_ptr_inc(tx_wp_reg) == tx_rp_reg);
    assign tx_full2 = tx_full1 || (tx_ptr_inc(tx_ptr_inc(tx_wp_reg)) == tx_rp_reg);
    assign expand   = crlf_expand_reg && (s_data.data_byte == CHAR_CR);

    // Operation decode and next state.
    always_comb begin
        rx_wp_next       = rx_wp_reg;
        rx_rp_next       = rx_rp_reg;
        tx_wp_next       = tx_wp_reg;
        tx_rp_next       = tx_rp_reg;
        driver_on_next   = driver_on_reg;
        receiver_on_next = receiver_on_reg;
        pend_next        = pend_reg;
        status_next      = ST_OK;
        sel_next         = SEL_NONE;
        rx_we            = 1'b0;
        rx_re            = 1'b0;
        tx_we            = 1'b0;
        tx_re            = 1'b0;
        tx_wdata         = s_data.data_byte;
        if (pend_reg) begin
            // Second half of an expanded carriage return.
            tx_we      = 1'b1;
            tx_wdata   = CHAR_CR;
            tx_wp_next = tx_ptr_inc(tx_wp_reg);
            pend_next  = 1'b0;
        end else if (accept) begin
            case (s_data.operation)
                OP_LINE_RX: begin
                    if (!receiver_on_reg) begin
                        status_next = ST_RX_DISABLED;
                    end else if (rx_full) begin
                        status_next = ST_RX_OVERFLOW;
                    end else begin
                        rx_we      = 1'b1;
                        rx_wp_next = rx_ptr_inc(rx_wp_reg);
                    end
                end
                OP_HOST_READ: begin
                    if (rx_empty) begin
                        status_next = ST_RX_EMPTY;
                    end else begin
                        rx_re      = 1'b1;
                        rx_rp_next = rx_ptr_inc(rx_rp_reg);
                        sel_next   = SEL_RX;
                    end
                end
                OP_HOST_WRITE: begin
                    if (expand ? tx_full2 : tx_full1) begin
                        status_next = ST_TX_FULL;
                    end else begin
                        tx_we      = 1'b1;
                        tx_wdata   = expand ? CHAR_LF : s_data.data_byte;
                        tx_wp_next = tx_ptr_inc(tx_wp_reg);
                        pend_next  = expand;
                    end
                end
                OP_TX_READY: begin
                    if (tx_empty) begin
                        status_next = ST_TX_IDLE;
                    end else begin
                        tx_re          = 1'b1;
                        tx_rp_next     = tx_ptr_inc(tx_rp_reg);
                        sel_next       = SEL_TX;
                        driver_on_next = 1'b1;
                        if (!local_echo_reg) begin
                            receiver_on_next = 1'b0;
                        end
                    end
                end
                OP_TX_DONE: begin
                    driver_on_next   = 1'b0;
                    receiver_on_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wp_reg       <= '0;
            rx_rp_reg       <= '0;
            tx_wp_reg       <= '0;
            tx_rp_reg       <= '0;
            driver_on_reg   <= 1'b0;
            receiver_on_reg <= 1'b1;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            local_echo_reg  <= 1'b0;
            crlf_expand_reg <= 1'b1;
        end else begin
            rx_wp_reg       <= rx_wp_next;
            rx_rp_reg       <= rx_rp_next;
            tx_wp_reg       <= tx_wp_next;
            tx_rp_reg       <= tx_rp_next;
            driver_on_reg   <= driver_on_next;
            receiver_on_reg <= receiver_on_next;
            pend_reg        <= pend_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_LOCAL_ECHO) begin
                    local_echo_reg <= cfg_data;
                end else if (cfg_index == CFG_CRLF_EXPAND) begin
                    crlf_expand_reg <= cfg_data;
                end
            end
        end
    end

    // Result register, loaded when a request is accepted.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg   <= status_next;
            sel_reg      <= sel_next;
            rx_avail_reg <= (rx_wp_next != rx_rp_next);
        end
    end

    // Receive store: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wp_reg] <= s_data.data_byte;
        end
        if (rx_re) begin
            rx_rdata_reg <= rx_mem[rx_rp_reg];
        end
    end

    // Transmit store: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wp_reg] <= tx_wdata;
        end
        if (tx_re) begin
            tx_rdata_reg <= tx_mem[tx_rp_reg];
        end
    end

    // Result byte from the store that was popped, else zero.
    always_comb begin
        case (sel_reg)
            SEL_RX:  out_byte_mux = rx_rdata_reg;
            SEL_TX:  out_byte_mux = tx_rdata_reg;
            default: out_byte_mux = 8'h00;
        endcase
    end

    // Result fields. Driver and receiver state only change with an accepted request
    // or the pending write, which leaves them alone, so they are read directly.
    assign m_valid                = out_valid_reg;
    assign m_data.status          = status_reg;
    assign m_data.out_byte        = out_byte_mux;
    assign m_data.driver_enable   = driver_on_reg;
    assign m_data.receiver_enable = receiver_on_reg;
    assign m_data.rx_available    = rx_avail_reg;

    // The pending write of an expanded carriage return is done once and then clears.
    `HDSFC_ASSERT_NEXT(a_pend_one_cycle, pend_reg, !pend_reg)
    // After the pending write the transmit ring cannot be empty.
    `HDSFC_ASSERT_NEXT(a_pend_fills_tx, pend_reg, tx_wp_reg != tx_rp_reg)
    // A stored line byte is reported as available.
    `HDSFC_ASSERT_NEXT(a_rx_push_avail, accept && rx_we, m_valid && m_data.rx_available)
    // A successful transmit pop turns the driver on in its result.
    `HDSFC_ASSERT_NEXT(a_tx_pop_driver, accept && tx_re,
        m_valid && m_data.driver_enable && (m_data.status == ST_OK))

endmodule
